### src/itaf_pkg.sv
// shared types, constants, microcode rom and helpers of the integer to ascii formatter
`default_nettype none
package itaf_pkg;

  // operand and digit store geometry
  localparam int VALUE_W         = 64;
  localparam int DIGIT_SLOTS_DEF = 22;
  localparam int DEC_DIGITS      = 20;
  localparam int OCT_DIGITS      = 22;
  localparam int HEX_NIBBLES     = 16;
  localparam int DD_BITS         = 4;
  localparam int DD_STEPS        = VALUE_W / DD_BITS;

  // conversion modes
  localparam logic [2:0] MODE_LIT  = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_SDEC = 3'd2;
  localparam logic [2:0] MODE_OCT  = 3'd3;
  localparam logic [2:0] MODE_HEXL = 3'd4;
  localparam logic [2:0] MODE_HEXU = 3'd5;

  // fixed characters
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_X     = 8'h78;
  localparam logic [7:0] ASCII_UA    = 8'h41;
  localparam logic [7:0] ASCII_LA    = 8'h61;

  // character source select
  localparam logic [2:0] CH_LIT   = 3'd0;
  localparam logic [2:0] CH_MINUS = 3'd1;
  localparam logic [2:0] CH_ZERO  = 3'd2;
  localparam logic [2:0] CH_X     = 3'd3;
  localparam logic [2:0] CH_DIGIT = 3'd4;

  // emission guard
  localparam logic [1:0] GD_NONE = 2'd0;
  localparam logic [1:0] GD_NEG  = 2'd1;
  localparam logic [1:0] GD_ALT  = 2'd2;

  // datapath operations
  localparam logic [2:0] DP_NONE   = 3'd0;
  localparam logic [2:0] DP_LOAD   = 3'd1;
  localparam logic [2:0] DP_DABBLE = 3'd2;
  localparam logic [2:0] DP_SKIP   = 3'd3;
  localparam logic [2:0] DP_EMIT   = 3'd4;

  // jump kinds
  localparam logic [2:0] JP_NEXT     = 3'd0;
  localparam logic [2:0] JP_GOTO     = 3'd1;
  localparam logic [2:0] JP_DISPATCH = 3'd2;
  localparam logic [2:0] JP_ITER     = 3'd3;
  localparam logic [2:0] JP_SKIP     = 3'd4;
  localparam logic [2:0] JP_EMIT     = 3'd5;

  // program addresses
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;
  localparam pc_t PC_FETCH = 4'd0;
  localparam pc_t PC_LIT   = 4'd1;
  localparam pc_t PC_OPRE  = 4'd2;
  localparam pc_t PC_HPRE0 = 4'd3;
  localparam pc_t PC_HPREX = 4'd4;
  localparam pc_t PC_DSIGN = 4'd5;
  localparam pc_t PC_DDAB  = 4'd6;
  localparam pc_t PC_SKIP  = 4'd7;
  localparam pc_t PC_EMIT  = 4'd8;

  // channel payloads
  typedef struct packed {
    logic [2:0]         mode;
    logic [VALUE_W-1:0] value;
    logic               alt_prefix;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  // one control word
  typedef struct packed {
    logic       accept;
    logic       emit;
    logic [2:0] char_sel;
    logic [1:0] guard;
    logic [2:0] dp_op;
    logic [2:0] jump;
    pc_t        target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    ucode_t uc;
    logic   adv;
    logic   emit_now;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic neg;
    logic alt;
    logic iter_done;
    logic skip_zero;
    logic more;
    logic out_free;
  } status_t;

  // control store
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_FETCH: w = '{1'b1, 1'b0, CH_LIT,   GD_NONE, DP_LOAD,   JP_DISPATCH, PC_FETCH};
      PC_LIT:   w = '{1'b0, 1'b1, CH_LIT,   GD_NONE, DP_NONE,   JP_GOTO,     PC_FETCH};
      PC_OPRE:  w = '{1'b0, 1'b1, CH_ZERO,  GD_ALT,  DP_NONE,   JP_GOTO,     PC_SKIP};
      PC_HPRE0: w = '{1'b0, 1'b1, CH_ZERO,  GD_ALT,  DP_NONE,   JP_NEXT,     PC_FETCH};
      PC_HPREX: w = '{1'b0, 1'b1, CH_X,     GD_ALT,  DP_NONE,   JP_GOTO,     PC_SKIP};
      PC_DSIGN: w = '{1'b0, 1'b1, CH_MINUS, GD_NEG,  DP_NONE,   JP_NEXT,     PC_FETCH};
      PC_DDAB:  w = '{1'b0, 1'b0, CH_LIT,   GD_NONE, DP_DABBLE, JP_ITER,     PC_FETCH};
      PC_SKIP:  w = '{1'b0, 1'b0, CH_LIT,   GD_NONE, DP_SKIP,   JP_SKIP,     PC_FETCH};
      PC_EMIT:  w = '{1'b0, 1'b1, CH_DIGIT, GD_NONE, DP_EMIT,   JP_EMIT,     PC_FETCH};
      default:  w = '{1'b0, 1'b0, CH_LIT,   GD_NONE, DP_NONE,   JP_GOTO,     PC_FETCH};
    endcase
    return w;
  endfunction

  // entry point for each mode
  function automatic pc_t dispatch(input logic [2:0] mode);
    pc_t p;
    unique case (mode) inside
      MODE_LIT:             p = PC_LIT;
      MODE_UDEC, MODE_SDEC: p = PC_DSIGN;
      MODE_OCT:             p = PC_OPRE;
      MODE_HEXL, MODE_HEXU: p = PC_HPRE0;
      default:              p = PC_FETCH;
    endcase
    return p;
  endfunction

  // digit value to ascii, both cases
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'b0, d};
    end else if (upper) begin
      c = ASCII_UA + {4'b0, d} - 8'd10;
    end else begin
      c = ASCII_LA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### src/itaf_seq.sv
// microcode sequencer: program counter, control store and jump logic
`default_nettype none
module itaf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2:0]          in_mode,
  input  itaf_pkg::status_t   status,
  output logic                in_ready,
  output itaf_pkg::ctrl_t     ctrl
);

  itaf_pkg::pc_t    pc_r;
  itaf_pkg::pc_t    pc_nxt;
  itaf_pkg::ucode_t uc;
  logic             guard_ok;
  logic             emit_now;
  logic             adv;

  // current control word
  assign uc = itaf_pkg::ucode_rom(pc_r);

  // guarded emission and stall
  always_comb begin
    unique case (uc.guard)
      itaf_pkg::GD_NEG: guard_ok = status.neg;
      itaf_pkg::GD_ALT: guard_ok = status.alt;
      default:          guard_ok = 1'b1;
    endcase
    emit_now = uc.emit & guard_ok;
    if (uc.accept) begin
      adv = in_valid;
    end else if (emit_now) begin
      adv = status.out_free;
    end else begin
      adv = 1'b1;
    end
  end

  // next step
  always_comb begin
    pc_nxt = pc_r;
    if (adv) begin
      unique case (uc.jump)
        itaf_pkg::JP_NEXT:     pc_nxt = pc_r + itaf_pkg::pc_t'(1);
        itaf_pkg::JP_GOTO:     pc_nxt = uc.target;
        itaf_pkg::JP_DISPATCH: pc_nxt = itaf_pkg::dispatch(in_mode);
        itaf_pkg::JP_ITER:     pc_nxt = status.iter_done ? pc_r + itaf_pkg::pc_t'(1) : pc_r;
        itaf_pkg::JP_SKIP:     pc_nxt = status.skip_zero ? pc_r : pc_r + itaf_pkg::pc_t'(1);
        itaf_pkg::JP_EMIT:     pc_nxt = status.more ? pc_r : uc.target;
        default:               pc_nxt = itaf_pkg::PC_FETCH;
      endcase
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= itaf_pkg::PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_ready      = uc.accept;
  assign ctrl.uc       = uc;
  assign ctrl.adv      = adv;
  assign ctrl.emit_now = emit_now;

endmodule
`default_nettype wire

### src/itaf_dp.sv
// datapath: operand shifter, digit store, bcd conversion and output register
`default_nettype none
module itaf_dp #(
  parameter int DIGIT_SLOTS = itaf_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  itaf_pkg::in_item_t  in_data,
  input  itaf_pkg::ctrl_t     ctrl,
  input  logic                out_ready,
  output itaf_pkg::status_t   status,
  output logic                out_valid,
  output itaf_pkg::out_item_t out_data
);

  localparam int VW        = itaf_pkg::VALUE_W;
  localparam int CNT_W     = $clog2(DIGIT_SLOTS + 1);
  localparam int IDX_W     = $clog2(DIGIT_SLOTS);
  localparam int ITER_W    = $clog2(itaf_pkg::DD_STEPS);
  localparam int OCT_EXT_W = 3 * DIGIT_SLOTS;
  localparam int HEX_EXT_W = 4 * DIGIT_SLOTS;

  typedef logic [DIGIT_SLOTS-1:0][3:0] digits_t;

  logic [VW-1:0]       mag_r, mag_nxt;
  digits_t             digits_r, digits_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                neg_r, neg_nxt;
  logic                alt_r, alt_nxt;
  logic                upper_r, upper_nxt;
  logic                out_valid_r, out_valid_nxt;
  itaf_pkg::out_item_t out_data_r, out_data_nxt;

  logic [OCT_EXT_W-1:0] oct_ext;
  logic [HEX_EXT_W-1:0] hex_ext;
  logic [IDX_W-1:0]     rd_idx;
  logic [3:0]           rd_digit;
  logic                 more;
  logic                 skip_zero;
  logic                 out_free;
  logic                 in_neg;
  digits_t              dab_digits;
  logic [VW-1:0]        dab_mag;
  digits_t              load_digits;
  itaf_pkg::out_item_t  emit_item;

  // digit read at the current top of the text
  assign rd_idx    = (count_r == '0) ? '0 : IDX_W'(count_r - CNT_W'(1));
  assign rd_digit  = digits_r[rd_idx];
  assign more      = count_r > CNT_W'(1);
  assign skip_zero = more && (rd_digit == 4'd0);
  assign out_free  = !out_valid_r || out_ready;
  assign in_neg    = (in_data.mode == itaf_pkg::MODE_SDEC) && in_data.value[VW-1];

  // digit fields of the raw operand for octal and hex
  assign oct_ext = OCT_EXT_W'(in_data.value);
  assign hex_ext = HEX_EXT_W'(in_data.value);

  always_comb begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      unique case (in_data.mode) inside
        itaf_pkg::MODE_OCT:                     load_digits[i] = {1'b0, oct_ext[3*i +: 3]};
        itaf_pkg::MODE_HEXL, itaf_pkg::MODE_HEXU: load_digits[i] = hex_ext[4*i +: 4];
        default:                                load_digits[i] = 4'd0;
      endcase
    end
  end

  // shift-and-add-3 binary to bcd, several operand bits per cycle
  always_comb begin
    dab_digits = digits_r;
    dab_mag    = mag_r;
    for (int s = 0; s < itaf_pkg::DD_BITS; s++) begin
      for (int d = 0; d < DIGIT_SLOTS; d++) begin
        if (dab_digits[d] >= 4'd5) begin
          dab_digits[d] = dab_digits[d] + 4'd3;
        end
      end
      for (int d = DIGIT_SLOTS - 1; d > 0; d--) begin
        dab_digits[d] = {dab_digits[d][2:0], dab_digits[d-1][3]};
      end
      dab_digits[0] = {dab_digits[0][2:0], dab_mag[VW-1]};
      dab_mag       = {dab_mag[VW-2:0], 1'b0};
    end
  end

  // character for the current step
  always_comb begin
    emit_item.last = 1'b0;
    case (ctrl.uc.char_sel)
      itaf_pkg::CH_LIT: begin
        emit_item.char_code = mag_r[7:0];
        emit_item.last      = 1'b1;
      end
      itaf_pkg::CH_MINUS: emit_item.char_code = itaf_pkg::ASCII_MINUS;
      itaf_pkg::CH_ZERO:  emit_item.char_code = itaf_pkg::ASCII_ZERO;
      itaf_pkg::CH_X:     emit_item.char_code = itaf_pkg::ASCII_X;
      itaf_pkg::CH_DIGIT: begin
        emit_item.char_code = itaf_pkg::digit_char(rd_digit, upper_r);
        emit_item.last      = !more;
      end
      default: emit_item.char_code = itaf_pkg::ASCII_ZERO;
    endcase
  end

  // datapath operation decode
  always_comb begin
    mag_nxt    = mag_r;
    digits_nxt = digits_r;
    count_nxt  = count_r;
    iter_nxt   = iter_r;
    neg_nxt    = neg_r;
    alt_nxt    = alt_r;
    upper_nxt  = upper_r;
    if (ctrl.adv) begin
      unique case (ctrl.uc.dp_op)
        itaf_pkg::DP_LOAD: begin
          mag_nxt    = in_neg ? (VW'(0) - in_data.value) : in_data.value;
          digits_nxt = load_digits;
          iter_nxt   = '0;
          neg_nxt    = in_neg;
          alt_nxt    = in_data.alt_prefix;
          upper_nxt  = in_data.mode == itaf_pkg::MODE_HEXU;
          unique case (in_data.mode) inside
            itaf_pkg::MODE_OCT:                       count_nxt = CNT_W'(itaf_pkg::OCT_DIGITS);
            itaf_pkg::MODE_HEXL, itaf_pkg::MODE_HEXU: count_nxt = CNT_W'(itaf_pkg::HEX_NIBBLES);
            itaf_pkg::MODE_UDEC, itaf_pkg::MODE_SDEC: count_nxt = CNT_W'(itaf_pkg::DEC_DIGITS);
            default:                                  count_nxt = count_r;
          endcase
        end
        itaf_pkg::DP_DABBLE: begin
          digits_nxt = dab_digits;
          mag_nxt    = dab_mag;
          iter_nxt   = iter_r + ITER_W'(1);
        end
        itaf_pkg::DP_SKIP: begin
          if (skip_zero) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        itaf_pkg::DP_EMIT: count_nxt = count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctrl.adv && ctrl.emit_now) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // operand, digits and beat payload
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    digits_r   <= digits_nxt;
    neg_r      <= neg_nxt;
    alt_r      <= alt_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
  end

  assign status.neg       = neg_r;
  assign status.alt       = alt_r;
  assign status.iter_done = iter_r == ITER_W'(itaf_pkg::DD_STEPS - 1);
  assign status.skip_zero = skip_zero;
  assign status.more      = more;
  assign status.out_free  = out_free;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule
`default_nettype wire

### src/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// Usage: one input beat carries a mode, a 64-bit value and an alternate-prefix
// flag; the block answers with the value's text as a run of output beats, one
// ascii character per beat, most significant digit first, last set on the
// final character. Both channels are valid/ready. Unused modes are accepted
// and give no characters.
// Decimal runs the binary-to-bcd loop, 4 operand bits a cycle; all radix
// modes include a scan over leading zero digits, one digit a cycle, then
// one character a cycle while the receiver is ready. A literal's character
// is written to the output register at the literal step after fetch;
// otherwise any sign or prefix character comes first and the digits follow
// the scan.
// The input is taken only at the sequencer's fetch step, so one value is in
// work at a time; the final character may still sit in the output register
// while the next value is accepted.
// A stalled receiver holds the output beat and freezes the sequencer at its
// next emitting step; nothing is dropped.
// Reset (synchronous, active low) returns the sequencer to fetch and empties
// the output register; no clearing pass is needed.
`default_nettype none
module integer_to_ascii_formatter #(
  parameter int DIGIT_SLOTS = itaf_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itaf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output itaf_pkg::out_item_t out_data
);

  itaf_pkg::ctrl_t   ctrl;
  itaf_pkg::status_t status;

  // program sequencer
  itaf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .status   (status),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // conversion datapath
  itaf_dp #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### src/itaf_chk.sv
// port-level checker of the integer to ascii formatter and its bind
`default_nettype none
module itaf_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input itaf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input itaf_pkg::out_item_t out_data
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a value that prints text keeps the input from being taken again in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode <= itaf_pkg::MODE_HEXU) |=> !in_ready)
    else $error("input taken again straight after a printing value");

  // no new value while the text before it is unfinished
  a_no_accept_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !in_ready)
    else $error("input ready in the middle of a text");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_ascii_formatter itaf_chk u_chk (.*);
`default_nettype wire
